// File: rtl/mesdf_pkg.sv
// Shared types and constants of the median, EMA and slew-limit distance filter.
package mesdf_pkg;

    localparam int DIST_W  = 16;
    localparam int ALPHA_W = 9;
    localparam int COUNT_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    localparam logic [DIST_W-1:0]  MAX_VALID_RESET  = 16'd6400;
    localparam logic [ALPHA_W-1:0] EMA_ALPHA_RESET  = 9'd77;
    localparam logic [DIST_W-1:0]  MAX_CHANGE_RESET = 16'd80;
    localparam logic [DIST_W-1:0]  FILL_DELTA_RESET = 16'd58;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHANGE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_DELTA = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] sample_distance;
        logic              burst_end;
    } in_item_t;

    typedef struct packed {
        logic [DIST_W-1:0]  filtered_distance;
        logic [DIST_W-1:0]  median_distance;
        logic [COUNT_W-1:0] valid_samples;
        logic               reading_ok;
        logic               spike_clamped;
        logic               filling;
    } out_item_t;

    // Control from the sequencer to the sorting chain
    typedef struct packed {
        logic insert;
        logic clear;
    } chain_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEDIAN,
        ST_MUL,
        ST_EMA,
        ST_CLAMP,
        ST_HYST,
        ST_OUT
    } state_t;

endpackage

// File: rtl/mesdf_cell.sv
// One cell of the insertion-sort chain: holds one sample and hands it to its right neighbour.
module mesdf_cell
    import mesdf_pkg::*;
(
    input  logic              clk,
    input  logic              insert,
    input  logic              occupied,
    input  logic              at_tail,
    input  logic [DIST_W-1:0] sample,
    input  logic [DIST_W-1:0] left_value,
    input  logic              left_greater,
    output logic [DIST_W-1:0] value,
    output logic              greater
);

    logic [DIST_W-1:0] value_reg;
    logic [DIST_W-1:0] value_next;

    assign greater = occupied && (value_reg > sample);
    assign value   = value_reg;

    // Take the neighbour's value when it moves right, else the new sample
    always_comb
    begin
        value_next = value_reg;
        if (insert && (greater || at_tail))
        begin
            value_next = left_greater ? left_value : sample;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// File: rtl/mesdf_sort_chain.sv
// Row of sorting cells with the fill count and the upper-median select.
module mesdf_sort_chain
    import mesdf_pkg::*;
#(
    parameter int SAMPLES_PER_BURST = 8,
    parameter int CNT_W = $clog2(SAMPLES_PER_BURST + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  chain_ctrl_t       ctrl,
    input  logic [DIST_W-1:0] sample,
    output logic [CNT_W-1:0]  count,
    output logic [DIST_W-1:0] median
);

    localparam int IDX_W = (SAMPLES_PER_BURST > 1) ? $clog2(SAMPLES_PER_BURST) : 1;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              full;
    logic              do_insert;
    logic [CNT_W-1:0]  half_count;
    logic [IDX_W-1:0]  median_idx;

    logic [DIST_W-1:0] cell_value   [SAMPLES_PER_BURST];
    logic              cell_greater [SAMPLES_PER_BURST];

    assign full      = (count_reg == CNT_W'(SAMPLES_PER_BURST));
    assign do_insert = ctrl.insert && !full;

    genvar i;
    generate
        for (i = 0; i < SAMPLES_PER_BURST; i++)
        begin : g_cell
            logic [DIST_W-1:0] left_value;
            logic              left_greater;

            if (i == 0)
            begin : g_head
                assign left_value   = '0;
                assign left_greater = 1'b0;
            end
            else
            begin : g_body
                assign left_value   = cell_value[i-1];
                assign left_greater = cell_greater[i-1];
            end

            mesdf_cell u_cell (
                .clk          (clk),
                .insert       (do_insert),
                .occupied     (CNT_W'(i) < count_reg),
                .at_tail      (CNT_W'(i) == count_reg),
                .sample       (sample),
                .left_value   (left_value),
                .left_greater (left_greater),
                .value        (cell_value[i]),
                .greater      (cell_greater[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign half_count = count_reg >> 1;
    assign median_idx = half_count[IDX_W-1:0];
    assign median     = cell_value[median_idx];
    assign count      = count_reg;

endmodule

// File: rtl/median_ema_slew_distance_filter.sv
// Top level of the median, EMA and slew-limit distance filter.
// Samples are taken one per cycle while in_stall is low: each valid sample (non-zero
// and below the configured validity limit) drops into its sorted place in a chain of
// cells in the cycle it is transferred. The sample that ends a burst also starts the
// sequencer, which picks the upper median and, for a burst with a valid sample, runs
// the EMA multiply, the slew limit and the filling hysteresis one step each; in_stall
// stays high from then until the result has been taken into the output register.
// A result is produced for every burst end, including bursts with no valid sample.
// Configuration writes take effect at once and are meant for idle periods.
module median_ema_slew_distance_filter
    import mesdf_pkg::*;
#(
    parameter int SAMPLES_PER_BURST = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIST_W-1:0]    cfg_data
);

    localparam int CNT_W  = $clog2(SAMPLES_PER_BURST + 1);
    localparam int PROD_W = ALPHA_W + DIST_W + 2;
    localparam int SUM_W  = PROD_W + 1;

    state_t state_reg, state_next;

    logic [DIST_W-1:0]  max_valid_reg, max_valid_next;
    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    logic [DIST_W-1:0]  max_change_reg, max_change_next;
    logic [DIST_W-1:0]  fill_delta_reg, fill_delta_next;

    logic [DIST_W-1:0]  ema_reg, ema_next;
    logic               ema_seeded_reg, ema_seeded_next;
    logic [DIST_W-1:0]  prev_reg, prev_next;
    logic               output_seen_reg, output_seen_next;
    logic [DIST_W-1:0]  ref_reg, ref_next;
    logic               ref_seen_reg, ref_seen_next;
    logic               fill_flag_reg, fill_flag_next;
    logic               out_valid_reg, out_valid_next;

    logic [DIST_W-1:0]        median_reg, median_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [DIST_W-1:0]        filt_reg, filt_next;
    logic                     clamped_reg, clamped_next;
    logic                     ok_reg, ok_next;
    out_item_t                out_data_reg, out_data_next;

    chain_ctrl_t        chain_ctrl;
    logic [CNT_W-1:0]   chain_count;
    logic [DIST_W-1:0]  chain_median;
    logic               in_xfer;
    logic               sample_ok;

    logic [ALPHA_W-1:0]       alpha_use;
    logic signed [DIST_W:0]   ema_diff;
    logic signed [SUM_W-1:0]  ema_sum;
    logic                     rising;
    logic [DIST_W-1:0]        change;
    logic [DIST_W:0]          up_sum;
    logic [DIST_W-1:0]        limited;
    logic [DIST_W:0]          drop_amt;
    logic [DIST_W:0]          rise_amt;
    logic                     drop_hit;
    logic                     rise_hit;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign sample_ok = (in_data.sample_distance != '0)
                    && (in_data.sample_distance < max_valid_reg);

    assign chain_ctrl.insert = in_xfer && sample_ok;
    assign chain_ctrl.clear  = (state_reg == ST_MEDIAN);

    mesdf_sort_chain #(
        .SAMPLES_PER_BURST (SAMPLES_PER_BURST),
        .CNT_W             (CNT_W)
    ) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (chain_ctrl),
        .sample (in_data.sample_distance),
        .count  (chain_count),
        .median (chain_median)
    );

    // EMA as ema + alpha * (median - ema) / 256, floored; an unseeded EMA uses weight one
    assign alpha_use = !ema_seeded_reg ? ALPHA_ONE
                     : ((alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg);
    assign ema_diff  = $signed({1'b0, median_reg}) - $signed({1'b0, ema_reg});
    assign ema_sum   = $signed({{(SUM_W-DIST_W-8){1'b0}}, ema_reg, 8'd0})
                     + SUM_W'(prod_reg);

    assign rising  = (ema_reg > prev_reg);
    assign change  = rising ? (ema_reg - prev_reg) : (prev_reg - ema_reg);
    assign up_sum  = {1'b0, prev_reg} + {1'b0, max_change_reg};
    assign limited = rising ? (up_sum[DIST_W] ? {DIST_W{1'b1}} : up_sum[DIST_W-1:0])
                   : ((prev_reg > max_change_reg) ? (prev_reg - max_change_reg) : '0);

    assign drop_amt = {1'b0, ref_reg} - {1'b0, filt_reg};
    assign rise_amt = {1'b0, filt_reg} - {1'b0, ref_reg};
    assign drop_hit = !drop_amt[DIST_W] && (drop_amt[DIST_W-1:0] >= fill_delta_reg);
    assign rise_hit = !rise_amt[DIST_W] && (rise_amt[DIST_W-1:0] >= fill_delta_reg);

    always_comb
    begin
        state_next       = state_reg;
        max_valid_next   = max_valid_reg;
        alpha_next       = alpha_reg;
        max_change_next  = max_change_reg;
        fill_delta_next  = fill_delta_reg;
        ema_next         = ema_reg;
        ema_seeded_next  = ema_seeded_reg;
        prev_next        = prev_reg;
        output_seen_next = output_seen_reg;
        ref_next         = ref_reg;
        ref_seen_next    = ref_seen_reg;
        fill_flag_next   = fill_flag_reg;
        out_valid_next   = out_valid_reg && out_stall;
        median_next      = median_reg;
        n_next           = n_reg;
        prod_next        = prod_reg;
        filt_next        = filt_reg;
        clamped_next     = clamped_reg;
        ok_next          = ok_reg;
        out_data_next    = out_data_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MAX_VALID:  max_valid_next  = cfg_data;
                CFG_EMA_ALPHA:  alpha_next      = cfg_data[ALPHA_W-1:0];
                CFG_MAX_CHANGE: max_change_next = cfg_data;
                CFG_FILL_DELTA: fill_delta_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && in_data.burst_end)
                begin
                    state_next = ST_MEDIAN;
                end
            end
            ST_MEDIAN:
            begin
                n_next       = chain_count;
                clamped_next = 1'b0;
                if (chain_count == '0)
                begin
                    // Empty burst: report the held output and leave the filter alone
                    filt_next   = prev_reg;
                    median_next = '0;
                    ok_next     = 1'b0;
                    state_next  = ST_OUT;
                end
                else
                begin
                    median_next = chain_median;
                    ok_next     = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = $signed({1'b0, alpha_use}) * ema_diff;
                state_next = ST_EMA;
            end
            ST_EMA:
            begin
                ema_next        = ema_sum[DIST_W+7:8];
                ema_seeded_next = 1'b1;
                state_next      = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                filt_next = ema_reg;
                if (output_seen_reg && (prev_reg != '0) && (change > max_change_reg))
                begin
                    filt_next    = limited;
                    ema_next     = limited;
                    clamped_next = 1'b1;
                end
                prev_next        = filt_next;
                output_seen_next = 1'b1;
                state_next       = ST_HYST;
            end
            ST_HYST:
            begin
                if (!ref_seen_reg)
                begin
                    ref_next       = filt_reg;
                    ref_seen_next  = 1'b1;
                    fill_flag_next = 1'b0;
                end
                else if (drop_hit)
                begin
                    ref_next       = filt_reg;
                    fill_flag_next = 1'b1;
                end
                else if (rise_hit)
                begin
                    ref_next       = filt_reg;
                    fill_flag_next = 1'b0;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.filtered_distance = filt_reg;
                    out_data_next.median_distance   = median_reg;
                    out_data_next.valid_samples     = COUNT_W'(n_reg);
                    out_data_next.reading_ok        = ok_reg;
                    out_data_next.spike_clamped     = clamped_reg;
                    out_data_next.filling           = fill_flag_reg;
                    out_valid_next                  = 1'b1;
                    state_next                      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            max_valid_reg   <= MAX_VALID_RESET;
            alpha_reg       <= EMA_ALPHA_RESET;
            max_change_reg  <= MAX_CHANGE_RESET;
            fill_delta_reg  <= FILL_DELTA_RESET;
            ema_reg         <= '0;
            ema_seeded_reg  <= 1'b0;
            prev_reg        <= '0;
            output_seen_reg <= 1'b0;
            ref_reg         <= '0;
            ref_seen_reg    <= 1'b0;
            fill_flag_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            max_valid_reg   <= max_valid_next;
            alpha_reg       <= alpha_next;
            max_change_reg  <= max_change_next;
            fill_delta_reg  <= fill_delta_next;
            ema_reg         <= ema_next;
            ema_seeded_reg  <= ema_seeded_next;
            prev_reg        <= prev_next;
            output_seen_reg <= output_seen_next;
            ref_reg         <= ref_next;
            ref_seen_reg    <= ref_seen_next;
            fill_flag_reg   <= fill_flag_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg   <= median_next;
        n_reg        <= n_next;
        prod_reg     <= prod_next;
        filt_reg     <= filt_next;
        clamped_reg  <= clamped_next;
        ok_reg       <= ok_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/mesdf_checker.sv
// Port-level checks of the distance filter, bound to the top level.
module mesdf_checker
    import mesdf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // A stalled result stays offered and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // A sample that does not end a burst leaves the input open next cycle
    a_mid_burst_open: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !in_data.burst_end |=> !in_stall)
        else $error("input stalled after a mid-burst sample");

    // An empty burst reports no median, no count and no clamp
    a_empty_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.reading_ok |->
            (out_data.valid_samples == '0) && (out_data.median_distance == '0)
            && !out_data.spike_clamped)
        else $error("empty burst result carries data");

    // A burst end always closes the input for the next cycle
    a_burst_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.burst_end |=> in_stall)
        else $error("input open straight after a burst end");

endmodule

bind median_ema_slew_distance_filter mesdf_checker u_mesdf_checker (.*);
